FILE: design/pwpf_pkg.sv
// ----------------------------------------------------------------------------
// pwpf_pkg
// Shared types and constants of the plane-wave phase factor core.
// ----------------------------------------------------------------------------
package pwpf_pkg;

    // Default field widths
    localparam int INDEX_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 24;

    // Datapath widths
    localparam int TURN_W  = 32;  // turn word, one full turn = 2^32
    localparam int ANGLE_W = 30;  // angle within a quadrant
    localparam int X_W     = 31;  // angle in radians, Q1.30
    localparam int X2_W    = 32;  // angle squared, Q2.30
    localparam int T_W     = 31;  // Horner term, Q1.30, at most one
    localparam int MAG_W   = 17;  // rounded Q1.15 magnitude, may reach 32768
    localparam int OUT_W   = 16;

    localparam logic [X_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [T_W-1:0] Q30_ONE     = 31'h4000_0000;

    // Horner series divisors
    localparam int SIN_TERMS = 6;
    localparam int COS_TERMS = 7;
    localparam int unsigned SIN_DIV [SIN_TERMS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_TERMS] = '{182, 132, 90, 56, 30, 12, 2};

    // Cycles through one Horner step
    localparam int HORNER_LAT = 3;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        quad_t                quad;
        logic [ANGLE_W-1:0]   angle;
    } turn_t;

endpackage

FILE: design/pwpf_front.sv
// ----------------------------------------------------------------------------
// pwpf_front
// Accepts items, forms the wrapped phase and splits it into quadrant and angle.
// ----------------------------------------------------------------------------
module pwpf_front #(
    parameter int INDEX_BITS = pwpf_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = pwpf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic        [FRAC_BITS-1:0]   frac_a,
    input  logic        [FRAC_BITS-1:0]   frac_b,
    input  logic        [FRAC_BITS-1:0]   frac_c,
    input  logic signed [INDEX_BITS-1:0]  miller_a,
    input  logic signed [INDEX_BITS-1:0]  miller_b,
    input  logic signed [INDEX_BITS-1:0]  miller_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pwpf_pkg::turn_t               out_item
);
    import pwpf_pkg::*;

    logic                 en;
    logic [FRAC_BITS-1:0] ext_a, ext_b, ext_c;
    logic [FRAC_BITS-1:0] prod_a_next, prod_b_next, prod_c_next;
    logic [FRAC_BITS-1:0] prod_a_reg, prod_b_reg, prod_c_reg;
    logic [FRAC_BITS-1:0] phase;
    logic [TURN_W-1:0]    turn_word;
    turn_t                turn_next, turn_reg;
    logic                 f1_vld_reg, f1_vld_next;
    logic                 f2_vld_reg, f2_vld_next;

    // advance whenever the last stage is empty or being taken
    assign en       = !f2_vld_reg || out_ready;
    assign in_ready = en;

    // sign-extend indices; products only matter modulo one turn
    assign ext_a = FRAC_BITS'(miller_a);
    assign ext_b = FRAC_BITS'(miller_b);
    assign ext_c = FRAC_BITS'(miller_c);

    assign prod_a_next = ext_a * frac_a;
    assign prod_b_next = ext_b * frac_b;
    assign prod_c_next = ext_c * frac_c;

    assign phase     = prod_a_reg + prod_b_reg + prod_c_reg;
    assign turn_word = TURN_W'(phase) << (TURN_W - FRAC_BITS);

    always_comb
    begin
        turn_next.quad  = quad_t'(turn_word[TURN_W-1 -: 2]);
        turn_next.angle = turn_word[ANGLE_W-1:0];
    end

    assign f1_vld_next = en ? in_valid   : f1_vld_reg;
    assign f2_vld_next = en ? f1_vld_reg : f2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= f1_vld_next;
            f2_vld_reg <= f2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
            turn_reg   <= turn_next;
        end
    end

    assign out_valid = f2_vld_reg;
    assign out_item  = turn_reg;

endmodule

FILE: design/pwpf_queue.sv
// ----------------------------------------------------------------------------
// pwpf_queue
// Short queue of turn words between the front and the back.
// ----------------------------------------------------------------------------
module pwpf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pwpf_pkg::turn_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output pwpf_pkg::turn_t  out_item
);
    import pwpf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    turn_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

FILE: design/pwpf_horner.sv
// ----------------------------------------------------------------------------
// pwpf_horner
// One Horner step t' = 1 - (x2 * t) / K, x2 in Q2.30 and t in Q1.30, floored at zero.
// ----------------------------------------------------------------------------
module pwpf_horner #(
    parameter int unsigned K = 2
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pwpf_pkg::X2_W-1:0]   x2_in,
    input  logic [pwpf_pkg::T_W-1:0]    t_in,
    output logic [pwpf_pkg::T_W-1:0]    t_out
);
    import pwpf_pkg::*;

    // reciprocal of K; the estimate is exact or one short
    localparam int          SHIFT = X2_W - 1 + $clog2(K);
    localparam logic [X2_W-1:0] RECIP = X2_W'((64'd1 << SHIFT) / K);
    localparam logic [X2_W-1:0] KVAL  = X2_W'(K);

    logic [X2_W+T_W-1:0]  prod1;
    logic [2*X2_W-1:0]    prod2;
    logic [X2_W-1:0]      n_next, n_reg, n_d_reg;
    logic [X2_W-1:0]      q0_next, q0_reg;
    logic [X2_W-1:0]      kq, rem, quo;
    logic [T_W-1:0]       t_next, t_reg;

    assign prod1  = (X2_W+T_W)'(x2_in) * (X2_W+T_W)'(t_in);
    assign n_next = prod1[ANGLE_W +: X2_W];

    assign prod2   = (2*X2_W)'(n_reg) * (2*X2_W)'(RECIP);
    assign q0_next = X2_W'(prod2 >> SHIFT);

    // correct the estimate by one where the remainder still holds K
    assign kq  = q0_reg * KVAL;
    assign rem = n_d_reg - kq;
    assign quo = (rem >= KVAL) ? q0_reg + 1'b1 : q0_reg;

    assign t_next = (quo > X2_W'(Q30_ONE)) ? '0 : T_W'(X2_W'(Q30_ONE) - quo);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            n_d_reg <= n_reg;
            q0_reg  <= q0_next;
            t_reg   <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

FILE: design/pwpf_back.sv
// ----------------------------------------------------------------------------
// pwpf_back
// Angle scaling, sine and cosine Horner chains, rounding and quadrant signs.
// ----------------------------------------------------------------------------
module pwpf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pwpf_pkg::turn_t                     in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pwpf_pkg::OUT_W-1:0]   phase_re,
    output logic signed [pwpf_pkg::OUT_W-1:0]   phase_im
);
    import pwpf_pkg::*;

    localparam int SIN_LAT = HORNER_LAT * SIN_TERMS;
    localparam int COS_LAT = HORNER_LAT * COS_TERMS;
    localparam int SM_LAT  = COS_LAT - SIN_LAT;
    localparam int X2_LAT  = COS_LAT - HORNER_LAT;
    localparam int DEPTH   = 2 + COS_LAT;

    function automatic logic [OUT_W-1:0] signed_q15(input logic [MAG_W-1:0] mag,
                                                     input logic neg);
        logic [MAG_W-1:0] negated;
        negated = ~mag + 1'b1;
        if (neg)
            return negated[OUT_W-1:0];
        else if (mag > MAG_W'(16'h7FFF))
            return 16'h7FFF;
        else
            return mag[OUT_W-1:0];
    endfunction

    logic                     en;
    logic [DEPTH-1:0]         vld_reg, vld_next;

    logic [X_W+ANGLE_W-1:0]   xprod;
    logic [X_W-1:0]           x_next, x_reg, x1_reg;
    quad_t                    quad_b0_reg, quad_b1_reg;
    logic [2*X_W-1:0]         x2prod;
    logic [X2_W-1:0]          x2_next, x2_reg;

    logic [X_W-1:0]           x_dly_reg  [SIN_LAT];
    logic [X2_W-1:0]          x2_dly_reg [X2_LAT];
    quad_t                    quad_dly_reg [COS_LAT];
    logic [X2_W-1:0]          x2_tap [COS_TERMS];

    logic [T_W-1:0]           sin_t [SIN_TERMS+1];
    logic [T_W-1:0]           cos_t [COS_TERMS+1];

    logic [X_W+T_W-1:0]       smprod;
    logic [X_W-1:0]           sm_next;
    logic [X_W-1:0]           sm_dly_reg [SM_LAT];

    logic [TURN_W-1:0]        cm_sum, sm_sum;
    logic [MAG_W-1:0]         cm, sm;
    logic [OUT_W-1:0]         re_next, im_next;
    logic [OUT_W-1:0]         re_reg, im_reg;
    logic                     out_vld_reg, out_vld_next;

    // hold the whole pipe while a finished result waits
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    assign vld_next     = en ? {vld_reg[DEPTH-2:0], in_valid} : vld_reg;
    assign out_vld_next = en ? vld_reg[DEPTH-1] : out_vld_reg;

    // quadrant angle to radians, then squared
    assign xprod   = (X_W+ANGLE_W)'(in_item.angle) * (X_W+ANGLE_W)'(HALF_PI_Q30);
    assign x_next  = xprod[ANGLE_W +: X_W];
    assign x2prod  = (2*X_W)'(x_reg) * (2*X_W)'(x_reg);
    assign x2_next = x2prod[ANGLE_W +: X2_W];

    // x2 taps, one per Horner step
    assign x2_tap[0] = x2_reg;
    for (genvar i = 1; i < COS_TERMS; i++)
    begin : g_tap
        assign x2_tap[i] = x2_dly_reg[HORNER_LAT*i-1];
    end

    assign sin_t[0] = Q30_ONE;
    for (genvar i = 0; i < SIN_TERMS; i++)
    begin : g_sin
        pwpf_horner #(.K(SIN_DIV[i])) u_step (
            .clk   (clk),
            .en    (en),
            .x2_in (x2_tap[i]),
            .t_in  (sin_t[i]),
            .t_out (sin_t[i+1])
        );
    end

    assign cos_t[0] = Q30_ONE;
    for (genvar i = 0; i < COS_TERMS; i++)
    begin : g_cos
        pwpf_horner #(.K(COS_DIV[i])) u_step (
            .clk   (clk),
            .en    (en),
            .x2_in (x2_tap[i]),
            .t_in  (cos_t[i]),
            .t_out (cos_t[i+1])
        );
    end

    assign smprod  = (X_W+T_W)'(x_dly_reg[SIN_LAT-1]) * (X_W+T_W)'(sin_t[SIN_TERMS]);
    assign sm_next = smprod[ANGLE_W +: X_W];

    // round half up to Q1.15
    assign cm_sum = TURN_W'(cos_t[COS_TERMS]) + TURN_W'(32'h4000);
    assign sm_sum = TURN_W'(sm_dly_reg[SM_LAT-1]) + TURN_W'(32'h4000);
    assign cm     = cm_sum[15 +: MAG_W];
    assign sm     = sm_sum[15 +: MAG_W];

    always_comb
    begin
        unique case (quad_dly_reg[COS_LAT-1])
            QUAD_0:
            begin
                re_next = signed_q15(cm, 1'b0);
                im_next = signed_q15(sm, 1'b1);
            end
            QUAD_1:
            begin
                re_next = signed_q15(sm, 1'b1);
                im_next = signed_q15(cm, 1'b1);
            end
            QUAD_2:
            begin
                re_next = signed_q15(cm, 1'b1);
                im_next = signed_q15(sm, 1'b0);
            end
            QUAD_3:
            begin
                re_next = signed_q15(sm, 1'b0);
                im_next = signed_q15(cm, 1'b0);
            end
            default:
            begin
                re_next = '0;
                im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_next;
            quad_b0_reg <= in_item.quad;
            x1_reg      <= x_reg;
            x2_reg      <= x2_next;
            quad_b1_reg <= quad_b0_reg;

            x_dly_reg[0]    <= x1_reg;
            x2_dly_reg[0]   <= x2_reg;
            quad_dly_reg[0] <= quad_b1_reg;
            sm_dly_reg[0]   <= sm_next;
            for (int i = 1; i < SIN_LAT; i++)
                x_dly_reg[i] <= x_dly_reg[i-1];
            for (int i = 1; i < X2_LAT; i++)
                x2_dly_reg[i] <= x2_dly_reg[i-1];
            for (int i = 1; i < COS_LAT; i++)
                quad_dly_reg[i] <= quad_dly_reg[i-1];
            for (int i = 1; i < SM_LAT; i++)
                sm_dly_reg[i] <= sm_dly_reg[i-1];

            if (vld_reg[DEPTH-1])
            begin
                re_reg <= re_next;
                im_reg <= im_next;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign phase_re  = re_reg;
    assign phase_im  = im_reg;

endmodule

FILE: design/plane_wave_phase_factor_core.sv
// ----------------------------------------------------------------------------
// plane_wave_phase_factor_core
// Complex phase factor exp(-2*pi*i*(n.t)) for one atom and one G-vector.
// ----------------------------------------------------------------------------
// Each transfer carries three fractional coordinates (unsigned fractions of a
// turn) and three signed Miller indices; each result carries the real and
// imaginary part of the phase factor in signed Q1.15, +1 saturating to 32767.
// The dot product wraps modulo one turn. With no back-pressure one item is
// taken every cycle and one result leaves every cycle. The latency is set by
// the cosine chain: seven Horner steps (multiply, reciprocal multiply,
// correct), behind the angle scaling and squaring registers, the two-stage
// front and the queue. The queue between front and back lets the input side
// keep taking transfers while the output is stalled, until its four entries
// are full.
// ----------------------------------------------------------------------------
module plane_wave_phase_factor_core #(
    parameter int INDEX_BITS = pwpf_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = pwpf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic        [FRAC_BITS-1:0]         frac_a,
    input  logic        [FRAC_BITS-1:0]         frac_b,
    input  logic        [FRAC_BITS-1:0]         frac_c,
    input  logic signed [INDEX_BITS-1:0]        miller_a,
    input  logic signed [INDEX_BITS-1:0]        miller_b,
    input  logic signed [INDEX_BITS-1:0]        miller_c,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pwpf_pkg::OUT_W-1:0]   phase_re,
    output logic signed [pwpf_pkg::OUT_W-1:0]   phase_im
);
    import pwpf_pkg::*;

    // front to queue
    logic   fq_valid, fq_ready;
    turn_t  fq_item;
    // queue to back
    logic   qb_valid, qb_ready;
    turn_t  qb_item;

    // form the wrapped phase and split it into quadrant and angle
    pwpf_front #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frac_a    (frac_a),
        .frac_b    (frac_b),
        .frac_c    (frac_c),
        .miller_a  (miller_a),
        .miller_b  (miller_b),
        .miller_c  (miller_c),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    // decouple the two halves so each can stall on its own
    pwpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // evaluate sine and cosine and apply the quadrant signs
    pwpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .phase_re  (phase_re),
        .phase_im  (phase_im)
    );

endmodule

FILE: dv/plane_wave_phase_factor_core_test.sv
// ----------------------------------------------------------------------------
// plane_wave_phase_factor_core_test
// Self-checking bench for the plane-wave phase factor core.
// ----------------------------------------------------------------------------
// The bench drives atom coordinates and Miller indices over the input
// valid/ready channel and checks every phase factor on the output channel.
// It opens with a short table of directed items: quadrant edges, wrapping
// phase, index and coordinate extremes. Random items follow. Both sides idle
// and stall at random, with some stretches at full rate. Each result is
// compared with a phase factor typed into the table or computed in the bench.
// ----------------------------------------------------------------------------
module plane_wave_phase_factor_core_test;

    import pwpf_pkg::*;

    localparam int FRAC_W = FRAC_BITS_DEF;
    localparam int IDX_W  = INDEX_BITS_DEF;

    localparam int NUM_DIRECTED  = 18;
    localparam int NUM_RANDOM    = 1700;
    localparam int PAUSE_AT      = 850;    // random items sent before the sender drains
    localparam int DRAIN_CYCLES  = 64;     // well past the core's latency
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;

    // Named extremes used in the directed table
    localparam logic [FRAC_W-1:0]       FRAC_ZERO    = '0;
    localparam logic [FRAC_W-1:0]       FRAC_MAX     = '1;
    localparam logic [FRAC_W-1:0]       FRAC_QUARTER = FRAC_W'(1) << (FRAC_W - 2);
    localparam logic [FRAC_W-1:0]       FRAC_EIGHTH  = FRAC_W'(1) << (FRAC_W - 3);
    localparam logic [FRAC_W-1:0]       FRAC_HALF    = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic [FRAC_W-1:0]       FRAC_3QUART  = FRAC_W'(3) << (FRAC_W - 2);
    localparam logic signed [IDX_W-1:0] MILLER_MIN   = 8'sh80;
    localparam logic signed [IDX_W-1:0] MILLER_MAX   = 8'sh7F;
    localparam logic signed [IDX_W-1:0] MILLER_ZERO  = 8'sh00;
    localparam logic signed [IDX_W-1:0] MILLER_ONE   = 8'sh01;
    localparam logic signed [IDX_W-1:0] MILLER_M1    = 8'shFF;
    localparam logic signed [15:0]      Q15_POS_ONE  = 16'sh7FFF;
    localparam logic signed [15:0]      Q15_NEG_ONE  = 16'sh8000;
    localparam logic signed [15:0]      Q15_ZERO     = 16'sh0000;

    // Fixed-point constants of the phase evaluation, Q2.30
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;
    localparam int          SINE_STEPS   = 6;
    localparam int          COSINE_STEPS = 7;
    localparam int unsigned SINE_DIVS   [SINE_STEPS]   = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COSINE_DIVS [COSINE_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } factor_t;

    typedef struct packed {
        logic [FRAC_W-1:0]       fa;
        logic [FRAC_W-1:0]       fb;
        logic [FRAC_W-1:0]       fc;
        logic signed [IDX_W-1:0] ma;
        logic signed [IDX_W-1:0] mb;
        logic signed [IDX_W-1:0] mc;
        bit                      typed;   // expected factor given in the row
        factor_t                 want;
    } atom_g_t;

    // Directed table: expectations typed in only where they follow at a glance
    localparam atom_g_t DIRECTED [NUM_DIRECTED] = '{
        // phase zero gives +1, saturated
        '{FRAC_ZERO, FRAC_ZERO, FRAC_ZERO, MILLER_ZERO, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_POS_ONE, Q15_ZERO}},
        // quarter, half and three-quarter turns
        '{FRAC_QUARTER, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_ZERO, Q15_NEG_ONE}},
        '{FRAC_HALF, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_NEG_ONE, Q15_ZERO}},
        '{FRAC_3QUART, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_ZERO, Q15_POS_ONE}},
        // two half turns wrap to zero
        '{FRAC_ZERO, FRAC_HALF, FRAC_HALF, MILLER_ZERO, MILLER_ONE, MILLER_ONE,
          1'b1, '{Q15_POS_ONE, Q15_ZERO}},
        // negative index: minus a quarter is three quarters
        '{FRAC_QUARTER, FRAC_ZERO, FRAC_ZERO, MILLER_M1, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_ZERO, Q15_POS_ONE}},
        // most negative index times a quarter wraps to whole turns
        '{FRAC_QUARTER, FRAC_ZERO, FRAC_ZERO, MILLER_MIN, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_POS_ONE, Q15_ZERO}},
        // largest index times a quarter leaves three quarters
        '{FRAC_ZERO, FRAC_ZERO, FRAC_QUARTER, MILLER_ZERO, MILLER_ZERO, MILLER_MAX,
          1'b1, '{Q15_ZERO, Q15_POS_ONE}},
        // full coordinates with zero indices
        '{FRAC_MAX, FRAC_MAX, FRAC_MAX, MILLER_ZERO, MILLER_ZERO, MILLER_ZERO,
          1'b1, '{Q15_POS_ONE, Q15_ZERO}},
        // the rest against the predictor
        '{FRAC_MAX, FRAC_MAX, FRAC_MAX, MILLER_MAX, MILLER_MAX, MILLER_MAX,
          1'b0, '0},
        '{FRAC_MAX, FRAC_MAX, FRAC_MAX, MILLER_MIN, MILLER_MIN, MILLER_MIN,
          1'b0, '0},
        '{FRAC_MAX, FRAC_ZERO, FRAC_MAX, MILLER_MIN, MILLER_MAX, MILLER_M1,
          1'b0, '0},
        '{24'h000001, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b0, '0},
        '{24'h3FFFFF, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b0, '0},
        '{FRAC_EIGHTH, FRAC_ZERO, FRAC_ZERO, MILLER_ONE, MILLER_ZERO, MILLER_ZERO,
          1'b0, '0},
        '{FRAC_ZERO, 24'h800001, FRAC_ZERO, MILLER_ZERO, MILLER_M1, MILLER_ZERO,
          1'b0, '0},
        '{24'h01E240, 24'hABCDEF, 24'h555555, -8'sd77, 8'sd45, 8'sd3,
          1'b0, '0},
        '{24'hAAAAAA, 24'h555555, 24'hC00001, 8'sd2, -8'sd3, 8'sd5,
          1'b0, '0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FRAC_W-1:0]        frac_a;
    logic [FRAC_W-1:0]        frac_b;
    logic [FRAC_W-1:0]        frac_c;
    logic signed [IDX_W-1:0]  miller_a;
    logic signed [IDX_W-1:0]  miller_b;
    logic signed [IDX_W-1:0]  miller_c;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [OUT_W-1:0]  phase_re;
    logic signed [OUT_W-1:0]  phase_im;

    factor_t factor_q[$];       // phase factors still owed by the core
    int      mismatches   = 0;
    int      factors_seen = 0;
    int      items_sent   = 0;
    int      cycle_count  = 0;
    bit      full_rate    = 1'b0; // both sides run without idling while set

    plane_wave_phase_factor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frac_a    (frac_a),
        .frac_b    (frac_b),
        .frac_c    (frac_c),
        .miller_a  (miller_a),
        .miller_b  (miller_b),
        .miller_c  (miller_c),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .phase_re  (phase_re),
        .phase_im  (phase_im)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One Horner step of the series: t' = 1 - x2*t/k, floored at zero
    function automatic logic [63:0] horner_step(input logic [63:0] t,
                                                input logic [63:0] x2,
                                                input int unsigned k);
        logic [63:0] d;
        d = ((x2 * t) >> 30) / k;
        return (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    endfunction

    // Apply the sign; a positive full-scale magnitude saturates
    function automatic logic signed [15:0] signed_q15(input logic [63:0] mag,
                                                      input bit neg);
        if (neg)
            return 16'(-mag);
        return (mag > 64'd32767) ? Q15_POS_ONE : 16'(mag);
    endfunction

    // Expected phase factor of one atom and one G-vector
    function automatic factor_t phase_factor(input atom_g_t it);
        longint      dot;
        logic [63:0] turn, ang, x, x2, s_term, c_term, s_mag, c_mag;
        quad_t       quad;
        factor_t     f;
        dot = longint'(it.ma) * longint'(it.fa)
            + longint'(it.mb) * longint'(it.fb)
            + longint'(it.mc) * longint'(it.fc);
        // wrap modulo one turn, then widen to a 32-bit turn word
        turn = (64'(dot) & ((64'd1 << FRAC_W) - 1)) << (32 - FRAC_W);
        quad = quad_t'(turn[31:30]);
        ang  = turn & (ONE_Q30 - 1);
        x    = (ang * HALF_PI_FIX) >> 30;
        x2   = (x * x) >> 30;
        s_term = ONE_Q30;
        for (int i = 0; i < SINE_STEPS; i++)
            s_term = horner_step(s_term, x2, SINE_DIVS[i]);
        c_term = ONE_Q30;
        for (int i = 0; i < COSINE_STEPS; i++)
            c_term = horner_step(c_term, x2, COSINE_DIVS[i]);
        s_mag = (((x * s_term) >> 30) + (64'd1 << 14)) >> 15;
        c_mag = (c_term + (64'd1 << 14)) >> 15;
        case (quad)
            QUAD_0:
            begin
                f.re = signed_q15(c_mag, 1'b0);
                f.im = signed_q15(s_mag, 1'b1);
            end
            QUAD_1:
            begin
                f.re = signed_q15(s_mag, 1'b1);
                f.im = signed_q15(c_mag, 1'b1);
            end
            QUAD_2:
            begin
                f.re = signed_q15(c_mag, 1'b1);
                f.im = signed_q15(s_mag, 1'b0);
            end
            default:
            begin
                f.re = signed_q15(s_mag, 1'b0);
                f.im = signed_q15(c_mag, 1'b0);
            end
        endcase
        return f;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (full_rate || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random item: half fully random; others near quadrant edges or with chosen indices
    function automatic atom_g_t random_item();
        atom_g_t it;
        int      kind;
        logic signed [IDX_W-1:0] edge_idx [5];
        edge_idx = '{MILLER_MIN, MILLER_M1, MILLER_ZERO, MILLER_ONE, MILLER_MAX};
        it       = '0;
        kind     = $urandom_range(0, 9);
        it.fa = FRAC_W'($urandom);
        it.fb = FRAC_W'($urandom);
        it.fc = FRAC_W'($urandom);
        it.ma = IDX_W'($urandom);
        it.mb = IDX_W'($urandom);
        it.mc = IDX_W'($urandom);
        case (kind)
            5:
            begin
                // near a quadrant boundary
                it.fa = FRAC_W'(($urandom_range(0, 3) << (FRAC_W - 2))
                        + $urandom_range(0, 64) - 32);
                it.ma = $urandom_range(0, 1) ? MILLER_ONE : MILLER_M1;
                it.mb = MILLER_ZERO;
                it.mc = MILLER_ZERO;
            end
            6:
            begin
                it.ma = IDX_W'($urandom_range(0, 4) - 2);
                it.mb = IDX_W'($urandom_range(0, 4) - 2);
                it.mc = IDX_W'($urandom_range(0, 4) - 2);
            end
            7:
            begin
                it.ma = edge_idx[$urandom_range(0, 4)];
                it.mb = edge_idx[$urandom_range(0, 4)];
                it.mc = edge_idx[$urandom_range(0, 4)];
                if ($urandom_range(0, 1))
                    it.fa = $urandom_range(0, 1) ? FRAC_MAX : FRAC_ZERO;
                if ($urandom_range(0, 1))
                    it.fb = $urandom_range(0, 1) ? FRAC_MAX : FRAC_HALF;
            end
            8, 9:
            begin
                // single axis
                it.mb = MILLER_ZERO;
                it.mc = MILLER_ZERO;
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Drive one item from a falling edge; return at the falling edge after the transfer
    task automatic send_item(input atom_g_t it);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frac_a   <= it.fa;
        frac_b   <= it.fb;
        frac_c   <= it.fc;
        miller_a <= it.ma;
        miller_b <= it.mb;
        miller_c <= it.mc;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        factor_q.push_back(it.typed ? it.want : phase_factor(it));
        items_sent++;
        @(negedge clk);
    endtask

    // Receiver: hold ready for a while, then stall for a random stretch
    always @(negedge clk)
    begin : result_sink
        int hold;
        if (rst_n)
        begin
            if (hold > 0)
                hold--;
            else if (out_ready)
            begin
                hold = idle_len();
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    hold--;
                end
            end
            else
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    // Compare each result transfer with the oldest owed phase factor
    always @(posedge clk)
    begin : result_check
        factor_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (factor_q.size() == 0)
                log_mismatch($sformatf("result with none owed: re %0d im %0d",
                                       phase_re, phase_im));
            else
            begin
                want = factor_q.pop_front();
                factors_seen++;
                if (phase_re !== want.re)
                    log_mismatch($sformatf("phase_re expected %0d got %0d",
                                           want.re, phase_re));
                if (phase_im !== want.im)
                    log_mismatch($sformatf("phase_im expected %0d got %0d",
                                           want.im, phase_im));
            end
        end
    end

    // Watchdog on a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d factors still owed",
                     cycle_count, factor_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        frac_a    = '0;
        frac_b    = '0;
        frac_c    = '0;
        miller_a  = '0;
        miller_b  = '0;
        miller_c  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED[i]);

        // Random items, with two full-rate stretches and a drain halfway
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            full_rate = (i >= 300 && i < 500) || (i >= 1300 && i < 1400);
            if (i == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                while (factor_q.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            send_item(random_item());
        end
        in_valid  <= 1'b0;
        full_rate = 1'b0;

        // Wait for every owed factor, then watch for stray results
        while (factor_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transfers (%0d directed), checked %0d phase factors",
                 items_sent, NUM_DIRECTED, factors_seen);
        $display("Covered quadrant edges, phase wrap, index and coordinate extremes");
        if (mismatches == 0 && factor_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
